// File: hdl/rmig_pkg.sv
// Shared types and constants for the surface-of-revolution index generator.
// No dependencies; imported by every module of the block.
`default_nettype none

package rmig_pkg;

  localparam int unsigned DataW   = 32;
  localparam int unsigned AddrW   = 4;
  localparam int unsigned CountW  = 11;
  localparam int unsigned FieldW  = 2;
  localparam logic [DataW-1:0] RestartMark = 32'hFFFF_FFFF;

  // Register indexes, taken from paddr[3:2].
  typedef enum logic [1:0] {
    REG_PART   = 2'd0,
    REG_KIND   = 2'd1,
    REG_SLICES = 2'd2,
    REG_RINGS  = 2'd3
  } reg_e;

  typedef enum logic [1:0] {
    PART_BOTTOM = 2'd0,
    PART_TOP    = 2'd1,
    PART_BODY   = 2'd2
  } part_e;

  typedef enum logic [1:0] {
    KIND_TRI   = 2'd0,
    KIND_CLOUD = 2'd1,
    KIND_WIRE  = 2'd2
  } kind_e;

  // Wireframe lists walk the outline first, then the cross lines.
  typedef enum logic [1:0] {
    PH_FIRST  = 2'd0,
    PH_MARK   = 2'd1,
    PH_SECOND = 2'd2
  } phase_e;

  typedef struct packed {
    part_e part;
    kind_e kind;
    logic  clear;
  } mode_t;

endpackage

`default_nettype wire

// File: hdl/revolution_mesh_index_gen.sv
// Index list generator for a surface of revolution. Each accepted request
// yields one index in the result register on the next cycle.
// It returns one index per cycle while out_ready_i is high; the output register is refilled in the
// same cycle it is taken, so requests and results stream back to back.
// Reset returns the registers to their defaults and clears the walk at once.
`default_nettype none

module revolution_mesh_index_gen #(
  parameter int unsigned MAX_SLICES = 1024,
  parameter int unsigned MAX_RINGS  = 1024
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [rmig_pkg::AddrW-1:0]  paddr,
  input  wire logic [rmig_pkg::DataW-1:0]  pwdata,
  output logic      [rmig_pkg::DataW-1:0]  prdata,
  output logic                             pready,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic                        restart_list_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic      [rmig_pkg::DataW-1:0]  index_value_o,
  output logic                             is_restart_o,
  output logic                             list_end_o
);
  import rmig_pkg::*;

  localparam int unsigned IW = $clog2(MAX_RINGS * (MAX_SLICES + 1));

  mode_t               mode;
  logic [CountW-1:0]   slice_count;
  logic [CountW-1:0]   ring_count;
  logic                accept;
  logic [IW-1:0]       index;
  logic                marker;
  logic                last;

  logic                valid_q, valid_d;
  logic [DataW-1:0]    value_q, value_d;
  logic                mark_q, mark_d;
  logic                end_q, end_d;

  rmig_regs u_regs (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .mode_o        (mode),
    .slice_count_o (slice_count),
    .ring_count_o  (ring_count)
  );

  rmig_walk #(
    .MAX_SLICES (MAX_SLICES),
    .MAX_RINGS  (MAX_RINGS),
    .IW         (IW)
  ) u_walk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .mode_i        (mode),
    .slice_count_i (slice_count),
    .ring_count_i  (ring_count),
    .step_i        (accept),
    .restart_i     (restart_list_i),
    .index_o       (index),
    .marker_o      (marker),
    .last_o        (last)
  );

  // A new request is taken whenever the result register is empty or is being
  // emptied by a transfer in the same cycle.
  assign in_ready_o = !valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    value_d = value_q;
    mark_d  = mark_q;
    end_d   = end_q;
    if (accept) begin
      valid_d = 1'b1;
      value_d = marker ? RestartMark : DataW'(index);
      mark_d  = marker;
      end_d   = last;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    mark_q  <= mark_d;
    end_q   <= end_d;
  end

  assign out_valid_o   = valid_q;
  assign index_value_o = value_q;
  assign is_restart_o  = mark_q;
  assign list_end_o    = end_q;

endmodule

`default_nettype wire

// File: hdl/rmig_regs.sv
// APB-style configuration registers of the index generator.
// Depends on rmig_pkg for register indexes and the mode struct.
`default_nettype none

module rmig_regs (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [rmig_pkg::AddrW-1:0]    paddr,
  input  wire logic [rmig_pkg::DataW-1:0]    pwdata,
  output logic      [rmig_pkg::DataW-1:0]    prdata,
  output logic                               pready,
  output rmig_pkg::mode_t                    mode_o,
  output logic      [rmig_pkg::CountW-1:0]   slice_count_o,
  output logic      [rmig_pkg::CountW-1:0]   ring_count_o
);
  import rmig_pkg::*;

  logic [FieldW-1:0] part_q, part_d;
  logic [FieldW-1:0] kind_q, kind_d;
  logic [CountW-1:0] slice_q, slice_d;
  logic [CountW-1:0] ring_q, ring_d;
  logic              wr_en;
  reg_e              idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = reg_e'(paddr[3:2]);

  always_comb begin
    part_d  = part_q;
    kind_d  = kind_q;
    slice_d = slice_q;
    ring_d  = ring_q;
    if (wr_en) begin
      unique case (idx)
        REG_PART:   part_d  = pwdata[FieldW-1:0];
        REG_KIND:   kind_d  = pwdata[FieldW-1:0];
        REG_SLICES: slice_d = pwdata[CountW-1:0];
        REG_RINGS:  ring_d  = pwdata[CountW-1:0];
        default:    part_d  = part_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      part_q  <= FieldW'(PART_BOTTOM);
      kind_q  <= FieldW'(KIND_TRI);
      slice_q <= CountW'(16);
      ring_q  <= CountW'(2);
    end else begin
      part_q  <= part_d;
      kind_q  <= kind_d;
      slice_q <= slice_d;
      ring_q  <= ring_d;
    end
  end

  always_comb begin
    unique case (idx)
      REG_PART:   prdata = DataW'(part_q);
      REG_KIND:   prdata = DataW'(kind_q);
      REG_SLICES: prdata = DataW'(slice_q);
      REG_RINGS:  prdata = DataW'(ring_q);
      default:    prdata = '0;
    endcase
  end

  // Codes above the last part or kind fall back to body grid and wireframe.
  always_comb begin
    mode_o.part  = (part_q >= FieldW'(PART_BODY)) ? PART_BODY : part_e'(part_q);
    mode_o.kind  = (kind_q >= FieldW'(KIND_WIRE)) ? KIND_WIRE : kind_e'(kind_q);
    mode_o.clear = wr_en;
  end

  assign slice_count_o = slice_q;
  assign ring_count_o  = ring_q;

endmodule

`default_nettype wire

// File: hdl/rmig_walk.sv
// Walk state and index computation for one list of the surface of revolution.
// Depends on rmig_pkg; driven by the configuration registers and the top level.
`default_nettype none

module rmig_walk #(
  parameter int unsigned MAX_SLICES = 1024,
  parameter int unsigned MAX_RINGS  = 1024,
  parameter int unsigned IW         = 21
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire rmig_pkg::mode_t             mode_i,
  input  wire logic [rmig_pkg::CountW-1:0] slice_count_i,
  input  wire logic [rmig_pkg::CountW-1:0] ring_count_i,
  input  wire logic                        step_i,
  input  wire logic                        restart_i,
  output logic      [IW-1:0]               index_o,
  output logic                             marker_o,
  output logic                             last_o
);
  import rmig_pkg::*;

  localparam int unsigned SW  = $clog2(MAX_SLICES + 2);
  localparam int unsigned RW  = $clog2(MAX_RINGS);
  localparam int unsigned RCW = $clog2(MAX_RINGS + 1);

  phase_e          phase_q, phase_d, cur_phase;
  logic [SW-1:0]   slice_q, slice_d, cur_s;
  logic [RW-1:0]   ring_q, ring_d, cur_i;
  logic [2:0]      group_q, group_d, cur_g;
  logic [IW-1:0]   base_q, base_d, cur_b;

  logic [SW-1:0]   sz_s, sz_sm1;
  logic [RCW-1:0]  sz_r;
  logic [RW-1:0]   rm1, rm2;
  logic [IW-1:0]   sx, s1x, bigs, nb;
  logic            bottom;

  always_comb begin
    if (slice_count_i == '0) begin
      sz_s = SW'(1);
    end else if (32'(slice_count_i) > MAX_SLICES) begin
      sz_s = SW'(MAX_SLICES);
    end else begin
      sz_s = SW'(slice_count_i);
    end
    if (ring_count_i < CountW'(2)) begin
      sz_r = RCW'(2);
    end else if (32'(ring_count_i) > MAX_RINGS) begin
      sz_r = RCW'(MAX_RINGS);
    end else begin
      sz_r = RCW'(ring_count_i);
    end
  end

  assign sz_sm1 = sz_s - SW'(1);
  assign rm1    = RW'(sz_r - RCW'(1));
  assign rm2    = RW'(sz_r - RCW'(2));

  // A restart request makes this transfer see a freshly cleared walk.
  assign cur_phase = restart_i ? PH_FIRST : phase_q;
  assign cur_s     = restart_i ? '0 : slice_q;
  assign cur_i     = restart_i ? '0 : ring_q;
  assign cur_g     = restart_i ? '0 : group_q;
  assign cur_b     = restart_i ? '0 : base_q;

  assign sx     = IW'(cur_s);
  assign bigs   = IW'(sz_s);
  assign s1x    = bigs + IW'(1);
  assign nb     = cur_b + s1x;
  assign bottom = (mode_i.part == PART_BOTTOM);

  always_comb begin
    index_o  = '0;
    marker_o = 1'b0;
    last_o   = 1'b0;
    phase_d  = cur_phase;
    slice_d  = cur_s;
    ring_d   = cur_i;
    group_d  = cur_g;
    base_d   = cur_b;

    unique case (mode_i.kind)
      KIND_TRI: begin
        if (mode_i.part == PART_BODY) begin
          case (cur_g)
            3'd0:    index_o = cur_b + sx;
            3'd1:    index_o = cur_b + sx + IW'(1);
            3'd2:    index_o = nb + sx;
            3'd4:    index_o = cur_b + sx + IW'(1);
            3'd5:    index_o = nb + sx + IW'(1);
            3'd6:    index_o = nb + sx;
            default: marker_o = 1'b1;
          endcase
          last_o = (cur_s == sz_sm1) && (cur_i == rm2) && (cur_g == 3'd7);
          if (cur_g != 3'd7) begin
            group_d = cur_g + 3'd1;
          end else begin
            group_d = '0;
            if (cur_i < rm2) begin
              ring_d = cur_i + RW'(1);
              base_d = nb;
            end else begin
              ring_d  = '0;
              base_d  = '0;
              slice_d = cur_s + SW'(1);
            end
          end
        end else begin
          case (cur_g[1:0])
            2'd0:    index_o = bottom ? '0 : s1x;
            2'd1:    index_o = bottom ? sx + IW'(2) : sx;
            2'd2:    index_o = sx + IW'(1);
            default: marker_o = 1'b1;
          endcase
          last_o = (cur_s == sz_sm1) && (cur_g[1:0] == 2'd3);
          if (cur_g[1:0] != 2'd3) begin
            group_d = {1'b0, cur_g[1:0] + 2'd1};
          end else begin
            group_d = '0;
            slice_d = cur_s + SW'(1);
          end
        end
      end

      KIND_CLOUD: begin
        if (mode_i.part == PART_BODY) begin
          index_o = cur_b + sx;
          last_o  = (cur_i == rm1) && (cur_s == sz_s);
          if (cur_s < sz_s) begin
            slice_d = cur_s + SW'(1);
          end else begin
            slice_d = '0;
            ring_d  = cur_i + RW'(1);
            base_d  = nb;
          end
        end else begin
          index_o = sx;
          last_o  = (cur_s == sz_s + SW'(1));
          slice_d = cur_s + SW'(1);
        end
      end

      default: begin
        if (mode_i.part == PART_BODY) begin
          if (cur_phase == PH_FIRST) begin
            case (cur_g)
              3'd0:    index_o = cur_b + sx;
              3'd1:    index_o = cur_b + sx + IW'(1);
              default: marker_o = 1'b1;
            endcase
            if (cur_g < 3'd2) begin
              group_d = cur_g + 3'd1;
            end else begin
              group_d = '0;
              if (cur_s < sz_sm1) begin
                slice_d = cur_s + SW'(1);
              end else begin
                slice_d = '0;
                if (cur_i < rm1) begin
                  ring_d = cur_i + RW'(1);
                  base_d = nb;
                end else begin
                  ring_d  = '0;
                  base_d  = '0;
                  phase_d = PH_MARK;
                end
              end
            end
          end else begin
            case (cur_g)
              3'd0:    index_o = cur_b + sx;
              3'd1:    index_o = nb + sx;
              default: marker_o = 1'b1;
            endcase
            last_o = (cur_s == sz_sm1) && (cur_i == rm2) && (cur_g >= 3'd2);
            if (cur_g < 3'd2) begin
              group_d = cur_g + 3'd1;
            end else begin
              group_d = '0;
              if (cur_i < rm2) begin
                ring_d = cur_i + RW'(1);
                base_d = nb;
              end else begin
                ring_d  = '0;
                base_d  = '0;
                slice_d = cur_s + SW'(1);
              end
            end
          end
        end else begin
          case (cur_phase)
            PH_FIRST: begin
              index_o = bottom ? sx + IW'(1) : sx;
              if (cur_s < sz_s) begin
                slice_d = cur_s + SW'(1);
              end else begin
                slice_d = '0;
                phase_d = PH_MARK;
              end
            end
            PH_MARK: begin
              marker_o = 1'b1;
              phase_d  = PH_SECOND;
            end
            default: begin
              case (cur_g)
                3'd0:    index_o = bottom ? '0 : s1x;
                3'd1:    index_o = bottom ? sx + IW'(1) : sx;
                default: marker_o = 1'b1;
              endcase
              last_o = (cur_s == sz_s) && (cur_g >= 3'd2);
              if (cur_g < 3'd2) begin
                group_d = cur_g + 3'd1;
              end else begin
                group_d = '0;
                slice_d = cur_s + SW'(1);
              end
            end
          endcase
        end
      end
    endcase

    if (last_o || mode_i.clear) begin
      phase_d = PH_FIRST;
      slice_d = '0;
      ring_d  = '0;
      group_d = '0;
      base_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_FIRST;
      slice_q <= '0;
      ring_q  <= '0;
      group_q <= '0;
      base_q  <= '0;
    end else if (step_i || mode_i.clear) begin
      phase_q <= phase_d;
      slice_q <= slice_d;
      ring_q  <= ring_d;
      group_q <= group_d;
      base_q  <= base_d;
    end
  end

endmodule

`default_nettype wire
